### rtl/htwd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htwd_pkg: shared types and codes of the Huffman tree walk decoder
// Holds the operation and register codes, the branch entry layout and the
// sequencer states.
// ----------------------------------------------------------------------------
package htwd_pkg;

  // Operation codes of a request
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_BRANCH_COUNT = 2'd0;
  localparam logic [1:0] CFG_SYMBOL_TOTAL = 2'd1;

  // Node ids below this are byte symbols
  localparam logic [8:0] SYMBOL_LIMIT = 9'd256;

  // One branch of the coding tree
  typedef struct packed {
    logic [8:0] parent;
    logic [8:0] child_one;
    logic [8:0] child_zero;
  } branch_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_FLUSH
  } walk_state_t;

endpackage

### rtl/huffman_tree_walk_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder_unit: Huffman decoder walking a branch table
// Load requests write branches into a synchronous table memory; decode
// requests push one byte, MSB first, through the tree and emit byte symbols.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                  Payload
//  -------   -------------------------  ------------------------------------
//  request   start, busy (taken when    operation, entry_index, entry_parent,
//            start && !busy)            entry_child_one, entry_child_zero,
//                                       data_byte
//  result    result_valid (one cycle,   symbol, last_of_byte, all_done
//            always taken)
//  config    cfg_valid, cfg_ready       cfg_index, cfg_data
//
// Sequence: a load request is written in its accept cycle and busy stays low.
// A decode request is accepted, then its bits are evaluated in turn: a bit
// that lands on a symbol moves on to the next bit, one that lands on an
// inner node first searches the table for the branch that owns the node.
// A flush follows the last bit or the symbol that reaches the total. The
// descending search, one read per cycle, sets the cost of inner nodes.
// Reset: synchronous, returns the walk to the root and resets the symbol
// counter and control registers; the table memory holds whatever it held until loaded.
// Stalls: the receiver cannot stall; busy holds off new requests during a
// decode. Configuration is always ready.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder_unit #(
  parameter int TREE_ENTRIES = 255
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic        operation,
  input  logic [7:0]  entry_index,
  input  logic [8:0]  entry_parent,
  input  logic [8:0]  entry_child_one,
  input  logic [8:0]  entry_child_zero,
  input  logic [7:0]  data_byte,
  // result channel
  output logic        result_valid,
  output logic [7:0]  symbol,
  output logic        last_of_byte,
  output logic        all_done,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW = (TREE_ENTRIES > 1) ? $clog2(TREE_ENTRIES) : 1;
  localparam logic [7:0] TE_COUNT = 8'(TREE_ENTRIES);

  // Branch table: one write port, one registered read port
  htwd_pkg::branch_t branch_mem [TREE_ENTRIES];
  htwd_pkg::branch_t rd_data;
  htwd_pkg::branch_t wr_data;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic              wr_en;

  // Control state
  htwd_pkg::walk_state_t state, state_next;
  logic          at_root, at_root_next;
  logic [AW-1:0] cur_branch, cur_branch_next;
  logic [31:0]   symbols_done, symbols_done_next;
  logic [7:0]    branch_count;
  logic [31:0]   symbol_total;
  logic          pend_valid, pend_valid_next;
  logic          cmp_valid, cmp_valid_next;
  logic          res_valid_next;

  // Working registers
  logic [7:0]    shift_byte, shift_byte_next;
  logic [2:0]    bit_cnt, bit_cnt_next;
  logic [AW-1:0] rd_idx, rd_idx_next;
  logic [8:0]    node, node_next;
  logic [AW-1:0] scan_addr, scan_addr_next;
  logic [7:0]    scan_left, scan_left_next;
  logic [AW-1:0] cmp_addr, cmp_addr_next;
  logic [7:0]    pend_symbol, pend_symbol_next;
  logic          pend_done, pend_done_next;
  logic [7:0]    res_symbol_next;
  logic          res_last_next;
  logic          res_done_next;

  // Derived values
  logic [7:0]    eff_count;
  logic [7:0]    root_wide;
  logic [AW-1:0] root_idx;
  logic [AW-1:0] walk_idx;
  logic [8:0]    node_sel;
  logic          is_symbol;
  logic [31:0]   sym_inc;
  logic          done_hit;
  logic          finished;
  logic          last_bit;
  logic          scan_hit;
  logic          scan_end;
  logic          take;
  logic [AW-1:0] next_branch;

  assign busy      = (state != htwd_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign take      = start && !busy;

  // Clamp the branch count to the table, a count of 0 acting as 1; the root is the last branch
  always_comb begin
    if (branch_count == 8'd0) begin
      eff_count = 8'd1;
    end else if (branch_count > TE_COUNT) begin
      eff_count = TE_COUNT;
    end else begin
      eff_count = branch_count;
    end
  end

  assign root_wide = eff_count - 8'd1;
  assign root_idx  = root_wide[AW-1:0];
  assign walk_idx  = at_root ? root_idx : cur_branch;

  assign node_sel  = shift_byte[7] ? rd_data.child_one : rd_data.child_zero;
  assign is_symbol = (node_sel < htwd_pkg::SYMBOL_LIMIT);
  assign sym_inc   = symbols_done + 32'd1;
  assign done_hit  = (sym_inc == symbol_total);
  assign finished  = (symbols_done >= symbol_total);
  assign last_bit  = (bit_cnt == 3'd7);

  // Search: compare the entry read last cycle, stop on a match or when
  // every branch below the count has been looked at
  assign scan_hit    = cmp_valid && (rd_data.parent == node);
  assign scan_end    = scan_hit || (!cmp_valid && (scan_left == 8'd0));
  assign next_branch = scan_hit ? cmp_addr : rd_idx;

  assign wr_addr = entry_index[AW-1:0];
  assign wr_data = '{parent: entry_parent, child_one: entry_child_one,
                     child_zero: entry_child_zero};

  // Table memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      branch_mem[wr_addr] <= wr_data;
    end
    rd_data <= branch_mem[rd_addr];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      htwd_pkg::ST_IDLE: begin
        if (take && (operation == htwd_pkg::OP_DECODE) && !finished) begin
          state_next = htwd_pkg::ST_EVAL;
        end
      end
      htwd_pkg::ST_EVAL: begin
        if (is_symbol) begin
          state_next = (done_hit || last_bit) ? htwd_pkg::ST_FLUSH
                                              : htwd_pkg::ST_EVAL;
        end else begin
          state_next = htwd_pkg::ST_SCAN;
        end
      end
      htwd_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_next = last_bit ? htwd_pkg::ST_FLUSH : htwd_pkg::ST_EVAL;
        end
      end
      htwd_pkg::ST_FLUSH: begin
        state_next = htwd_pkg::ST_IDLE;
      end
      default: begin
        state_next = htwd_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and outputs
  always_comb begin
    rd_addr           = walk_idx;
    wr_en             = 1'b0;
    at_root_next      = at_root;
    cur_branch_next   = cur_branch;
    symbols_done_next = symbols_done;
    pend_valid_next   = pend_valid;
    pend_symbol_next  = pend_symbol;
    pend_done_next    = pend_done;
    cmp_valid_next    = cmp_valid;
    cmp_addr_next     = cmp_addr;
    shift_byte_next   = shift_byte;
    bit_cnt_next      = bit_cnt;
    rd_idx_next       = rd_idx;
    node_next         = node;
    scan_addr_next    = scan_addr;
    scan_left_next    = scan_left;
    res_valid_next    = 1'b0;
    res_symbol_next   = pend_symbol;
    res_last_next     = 1'b0;
    res_done_next     = pend_done;
    case (state)
      htwd_pkg::ST_IDLE: begin
        if (take) begin
          if (operation == htwd_pkg::OP_LOAD) begin
            // drop loads beyond the table
            wr_en = (entry_index < TE_COUNT);
          end else if (!finished) begin
            shift_byte_next = data_byte;
            bit_cnt_next    = 3'd0;
            rd_idx_next     = walk_idx;
            pend_valid_next = 1'b0;
          end
        end
      end
      htwd_pkg::ST_EVAL: begin
        shift_byte_next = {shift_byte[6:0], 1'b0};
        if (is_symbol) begin
          // release the held symbol, hold the new one until we know
          // whether it ends the byte
          res_valid_next    = pend_valid;
          pend_valid_next   = 1'b1;
          pend_symbol_next  = node_sel[7:0];
          pend_done_next    = done_hit;
          symbols_done_next = sym_inc;
          at_root_next      = 1'b1;
          bit_cnt_next      = bit_cnt + 3'd1;
          rd_addr           = root_idx;
          rd_idx_next       = root_idx;
        end else begin
          node_next      = node_sel;
          scan_addr_next = root_idx;
          scan_left_next = eff_count;
          cmp_valid_next = 1'b0;
        end
      end
      htwd_pkg::ST_SCAN: begin
        if (scan_end) begin
          cur_branch_next = next_branch;
          at_root_next    = 1'b0;
          rd_addr         = next_branch;
          rd_idx_next     = next_branch;
          bit_cnt_next    = bit_cnt + 3'd1;
          cmp_valid_next  = 1'b0;
        end else begin
          rd_addr = scan_addr;
          if (scan_left != 8'd0) begin
            cmp_valid_next = 1'b1;
            cmp_addr_next  = scan_addr;
            scan_addr_next = scan_addr - AW'(1);
            scan_left_next = scan_left - 8'd1;
          end else begin
            cmp_valid_next = 1'b0;
          end
        end
      end
      htwd_pkg::ST_FLUSH: begin
        res_valid_next  = pend_valid;
        res_last_next   = 1'b1;
        pend_valid_next = 1'b0;
      end
      default: begin
        rd_addr = walk_idx;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= htwd_pkg::ST_IDLE;
      at_root      <= 1'b1;
      cur_branch   <= '0;
      symbols_done <= 32'd0;
      branch_count <= 8'd1;
      symbol_total <= 32'd0;
      pend_valid   <= 1'b0;
      cmp_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      at_root      <= at_root_next;
      cur_branch   <= cur_branch_next;
      symbols_done <= symbols_done_next;
      pend_valid   <= pend_valid_next;
      cmp_valid    <= cmp_valid_next;
      result_valid <= res_valid_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          htwd_pkg::CFG_BRANCH_COUNT: branch_count <= cfg_data[7:0];
          htwd_pkg::CFG_SYMBOL_TOTAL: symbol_total <= cfg_data;
          default: begin
            branch_count <= branch_count;
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    shift_byte   <= shift_byte_next;
    bit_cnt      <= bit_cnt_next;
    rd_idx       <= rd_idx_next;
    node         <= node_next;
    scan_addr    <= scan_addr_next;
    scan_left    <= scan_left_next;
    cmp_addr     <= cmp_addr_next;
    pend_symbol  <= pend_symbol_next;
    pend_done    <= pend_done_next;
    symbol       <= res_symbol_next;
    last_of_byte <= res_last_next;
    all_done     <= res_done_next;
  end

endmodule

### rtl/htwd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htwd_checker: port-level checks of the Huffman tree walk decoder
// Watches the request and result channels and flags results that break the
// decode sequencing.
// ----------------------------------------------------------------------------
module htwd_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       operation,
  input logic       result_valid,
  input logic       last_of_byte,
  input logic       all_done
);

  // Results only come out of a decode in progress
  a_result_in_decode: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result without a decode in progress");

  // A load finishes in its accept cycle
  a_load_single_cycle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (operation == htwd_pkg::OP_LOAD)) |=> (!busy && !result_valid))
    else $error("load request kept the block busy or made a result");

  // The symbol that reaches the total ends the byte
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && all_done) |-> last_of_byte)
    else $error("final symbol not marked last of byte");

  // The last symbol of a byte leaves the block ready for the next request
  a_last_frees_block: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_of_byte) |-> !busy)
    else $error("still busy after last symbol of byte");

endmodule

bind huffman_tree_walk_decoder_unit htwd_checker u_htwd_checker (.*);

### sim/huffman_tree_walk_decoder_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder_unit_test: self-checking bench of the tree walker
// Preloads the whole branch table, runs directed trees through the corner
// cases (zero total, dead ends, branch count 0 and 255, early stop, lowered
// total, unmapped register), then random trees with random data bytes. A
// behavioral walker predicts every symbol; a monitor checks each strobe.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder_unit_test;

  localparam int          TREE_SLOTS      = 255;
  localparam int          RANDOM_REQUESTS = 140;
  localparam int          TIMEOUT_NS      = 12_000_000;
  // Register indexes with no register behind them
  localparam logic [1:0]  CFG_SPARE_A     = 2'd2;
  localparam logic [1:0]  CFG_SPARE_B     = 2'd3;
  // Inner node id that no directed branch claims as parent
  localparam logic [8:0]  DEAD_END_NODE   = 9'd511;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last_of_byte;
    logic       all_done;
  } decoded_symbol_t;

  // Drive every input to a known value from time zero
  logic        clk              = 1'b0;
  logic        rst              = 1'b1;
  logic        start            = 1'b0;
  logic        operation        = htwd_pkg::OP_LOAD;
  logic [7:0]  entry_index      = '0;
  logic [8:0]  entry_parent     = '0;
  logic [8:0]  entry_child_one  = '0;
  logic [8:0]  entry_child_zero = '0;
  logic [7:0]  data_byte        = '0;
  logic        cfg_valid        = 1'b0;
  logic [1:0]  cfg_index        = htwd_pkg::CFG_BRANCH_COUNT;
  logic [31:0] cfg_data         = '0;
  logic        busy;
  logic        result_valid;
  logic [7:0]  symbol;
  logic        last_of_byte;
  logic        all_done;
  logic        cfg_ready;

  // Walker model state, starting at the reset values
  htwd_pkg::branch_t tree_model [TREE_SLOTS];
  logic [7:0]  walk_branch      = '0;
  logic        walk_at_root     = 1'b1;
  logic [31:0] decoded_count    = '0;
  logic [7:0]  cfg_branch_count = 8'd1;
  logic [31:0] cfg_symbol_total = '0;

  decoded_symbol_t symbol_expect_q [$];
  int unsigned     mismatch_count = 0;
  int unsigned     requests_taken = 0;
  int unsigned     burst_left     = 8;

  huffman_tree_walk_decoder_unit #(
    .TREE_ENTRIES(TREE_SLOTS)
  ) u_top (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .operation        (operation),
    .entry_index      (entry_index),
    .entry_parent     (entry_parent),
    .entry_child_one  (entry_child_one),
    .entry_child_zero (entry_child_zero),
    .data_byte        (data_byte),
    .result_valid     (result_valid),
    .symbol           (symbol),
    .last_of_byte     (last_of_byte),
    .all_done         (all_done),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // A count of 0 acts as 1; clamp to the table size as well
  function automatic int unsigned live_branches();
    if (cfg_branch_count == 8'd0) return 1;
    if (32'(cfg_branch_count) > TREE_SLOTS) return TREE_SLOTS;
    return 32'(cfg_branch_count);
  endfunction

  // Walk one data byte MSB first through the modeled table and queue the
  // symbols it yields. Hold the newest symbol back so that the final one of
  // the byte can be flagged before it is queued.
  task automatic walk_decode_byte(input logic [7:0] data);
    logic [7:0]      bits;
    logic [8:0]      node;
    int unsigned     idx;
    int              scan;
    bit              stop;
    bit              have_pending;
    decoded_symbol_t pending;
    bits = data;
    stop = 1'b0;
    have_pending = 1'b0;
    pending = '0;
    // Drop the byte once the symbol budget is spent
    if (decoded_count >= cfg_symbol_total) return;
    for (int k = 0; k < 8 && !stop; k++) begin
      // The root follows the branch count at the moment it is used
      idx = walk_at_root ? live_branches() - 1 : 32'(walk_branch);
      if (idx >= TREE_SLOTS) idx = TREE_SLOTS - 1;
      node = bits[7] ? tree_model[idx].child_one : tree_model[idx].child_zero;
      bits = bits << 1;
      if (node < htwd_pkg::SYMBOL_LIMIT) begin
        if (have_pending) symbol_expect_q.push_back(pending);
        decoded_count++;
        walk_at_root = 1'b1;
        pending.symbol = node[7:0];
        pending.last_of_byte = 1'b0;
        pending.all_done = (decoded_count == cfg_symbol_total);
        have_pending = 1'b1;
        // Stop mid-byte when the total is reached
        stop = pending.all_done;
      end else begin
        // Descend to the highest live branch owned by this node; with no owner
        // stay put, pinning the root by index if the walk was there
        scan = int'(live_branches()) - 1;
        while (scan >= 0 && tree_model[scan].parent != node) scan--;
        walk_branch = (scan >= 0) ? 8'(scan) : 8'(idx);
        walk_at_root = 1'b0;
      end
    end
    if (have_pending) begin
      pending.last_of_byte = 1'b1;
      symbol_expect_q.push_back(pending);
    end
  endtask

  // Present one request, hold it until taken, then advance the model. Start
  // stays high into the next request unless the burst ends here.
  task automatic send_request(input logic op, input logic [7:0] slot,
                              input logic [8:0] parent_id, one_id, zero_id,
                              input logic [7:0] data);
    int unsigned gap;
    if (!start) start <= 1'b1;
    operation        <= op;
    entry_index      <= slot;
    entry_parent     <= parent_id;
    entry_child_one  <= one_id;
    entry_child_zero <= zero_id;
    data_byte        <= data;
    @(posedge clk);
    while (busy) @(posedge clk);
    // Taken at this edge; count only requests the block acts on
    if (op == htwd_pkg::OP_LOAD) begin
      if (32'(slot) < TREE_SLOTS) begin
        tree_model[slot] = '{parent: parent_id, child_one: one_id, child_zero: zero_id};
        requests_taken++;
      end
    end else begin
      if (decoded_count < cfg_symbol_total) requests_taken++;
      walk_decode_byte(data);
    end
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      // Mostly short bursts, now and then a long stretch with no gap
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_branch(input logic [7:0] slot,
                             input logic [8:0] parent_id, one_id, zero_id);
    send_request(htwd_pkg::OP_LOAD, slot, parent_id, one_id, zero_id,
                 8'($urandom_range(0, 255)));
  endtask

  task automatic decode_byte(input logic [7:0] data);
    send_request(htwd_pkg::OP_DECODE, 8'($urandom_range(0, 255)),
                 9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                 9'($urandom_range(0, 511)), data);
  endtask

  // Stop requesting, wait for every predicted symbol, then let a byte that
  // yields nothing finish its walk: eight full table scans at most.
  task automatic settle();
    int unsigned hold;
    if (start) start <= 1'b0;
    while (symbol_expect_q.size() != 0) @(posedge clk);
    hold = 8 * (live_branches() + 4) + 8;
    repeat (hold) @(posedge clk);
  endtask

  // Write both registers, and optionally an unmapped index, with the block idle
  task automatic set_registers(input logic [31:0] count_word, input logic [31:0] total_word,
                               input bit poke_unmapped);
    logic [1:0]  reg_index [3];
    logic [31:0] reg_word [3];
    int unsigned writes;
    settle();
    reg_index[0] = htwd_pkg::CFG_BRANCH_COUNT;
    reg_word[0]  = count_word;
    reg_index[1] = htwd_pkg::CFG_SYMBOL_TOTAL;
    reg_word[1]  = total_word;
    reg_index[2] = $urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B;
    reg_word[2]  = $urandom;
    writes = poke_unmapped ? 3 : 2;
    for (int i = 0; i < writes; i++) begin
      if (i == 0) cfg_valid <= 1'b1;
      cfg_index <= reg_index[i];
      cfg_data  <= reg_word[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      if (reg_index[i] == htwd_pkg::CFG_BRANCH_COUNT) cfg_branch_count = reg_word[i][7:0];
      else if (reg_index[i] == htwd_pkg::CFG_SYMBOL_TOTAL) cfg_symbol_total = reg_word[i];
    end
    cfg_valid <= 1'b0;
  endtask

  // Load a tree of n branches at slots 0..n-1. Branch i owns node 256+i and
  // points only at symbols or lower branches, so every walk ends in a symbol.
  // Noisy trees break that now and then: stray children, foreign owners.
  task automatic build_tree(input int unsigned n, input bit noisy);
    logic [8:0] kid [2];
    logic [8:0] owner;
    for (int i = 0; i < n; i++) begin
      owner = htwd_pkg::SYMBOL_LIMIT + 9'(i);
      for (int c = 0; c < 2; c++) begin
        if (i == 0 || $urandom_range(0, 1) == 0) kid[c] = 9'($urandom_range(0, 255));
        else kid[c] = htwd_pkg::SYMBOL_LIMIT + 9'($urandom_range(0, i - 1));
      end
      if (noisy && $urandom_range(0, 3) == 0) begin
        kid[$urandom_range(0, 1)] = 9'($urandom_range(0, 511));
        if ($urandom_range(0, 1)) owner = 9'($urandom_range(0, 511));
      end
      load_branch(8'(i), owner, kid[1], kid[0]);
    end
  endtask

  // Fill every slot so that no walk or scan ever reads an unloaded entry;
  // a load at the slot past the table must be dropped.
  task automatic test_table_preload();
    build_tree(TREE_SLOTS, 1'b0);
    load_branch(8'd255, 9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                9'($urandom_range(0, 511)));
  endtask

  // Symbol total is still at its reset value of zero: bytes yield nothing
  task automatic test_zero_total();
    decode_byte(8'hff);
    decode_byte(8'h00);
  endtask

  // Deepest table: root at slot 254, every descent scans from the top
  task automatic test_full_depth_tree();
    set_registers(32'hffff_ffff, 32'hffff_ffff, 1'b1);
    decode_byte(8'h00);
    decode_byte(8'hff);
    decode_byte(8'h5a);
  endtask

  // Three branches: the root sends 0 to 'A' and 1 to branch 1; branch 1 sends
  // 0 to symbol 0xff and 1 to branch 0; branch 0 sends 1 to symbol 0 and 0
  // to a node that no branch owns, so the walk sticks there.
  task automatic test_hand_built_tree();
    load_branch(8'd0, htwd_pkg::SYMBOL_LIMIT + 9'd0, 9'h000, DEAD_END_NODE);
    load_branch(8'd1, htwd_pkg::SYMBOL_LIMIT + 9'd1, htwd_pkg::SYMBOL_LIMIT + 9'd0, 9'h0ff);
    load_branch(8'd2, htwd_pkg::SYMBOL_LIMIT + 9'd2, htwd_pkg::SYMBOL_LIMIT + 9'd1, 9'h041);
    set_registers(32'h1234_5603, 32'hffff_ffff, 1'b0);
    decode_byte(8'h00);   // eight symbols from one byte
    decode_byte(8'hff);   // two symbols, walk left inside the tree
    decode_byte(8'h00);   // stuck on the dead end, nothing out
    decode_byte(8'h80);   // leave the dead end, then seven from the root
    decode_byte(8'h40);   // reach the 0xff leaf
  endtask

  // Branch count 0 acts as 1: the root is slot 0, whose 0 child has no owner,
  // so the walk leaves the root flag but keeps the same slot
  task automatic test_unit_branch_count();
    set_registers(32'hffff_ff00, 32'hffff_ffff, 1'b1);
    decode_byte(8'h55);
  endtask

  // Stop mid-byte at the total, then drop bytes, then lower the total to zero
  task automatic test_early_stop();
    set_registers(32'd3, decoded_count + 32'd3, 1'b0);
    decode_byte(8'h00);
    decode_byte(8'hff);
    set_registers(32'd3, 32'd0, 1'b0);
    decode_byte(8'h00);
  endtask

  // Random trees under random settings, fed random bytes with a few stray
  // loads mixed in that may break the tree under the walker
  task automatic test_random_streams();
    int unsigned first_taken;
    int unsigned n;
    int unsigned nbytes;
    logic [31:0] count_word;
    logic [31:0] total_word;
    first_taken = requests_taken;
    while (requests_taken - first_taken < RANDOM_REQUESTS) begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 48) : $urandom_range(2, 12);
      build_tree(n, $urandom_range(0, 3) == 0);
      count_word = $urandom;
      count_word[7:0] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, n)) : 8'(n);
      case ($urandom_range(0, 9))
        0, 1:    total_word = 32'hffff_ffff;
        2:       total_word = $urandom_range(0, decoded_count);
        3:       total_word = decoded_count + $urandom_range(1, 4);
        default: total_word = decoded_count + $urandom_range(10, 60);
      endcase
      set_registers(count_word, total_word, $urandom_range(0, 3) == 0);
      nbytes = $urandom_range(6, 30);
      repeat (nbytes) begin
        if ($urandom_range(0, 9) == 0)
          load_branch(8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)),
                      9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
        else
          decode_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Check each strobed symbol against the oldest prediction, field by field
  always @(posedge clk) begin : check_symbols
    decoded_symbol_t want;
    if (!rst && result_valid) begin
      if (symbol_expect_q.size() == 0) begin
        report_mismatch($sformatf("symbol %02h strobed with none predicted", symbol));
      end else begin
        want = symbol_expect_q.pop_front();
        if (symbol !== want.symbol)
          report_mismatch($sformatf("symbol %02h, predicted %02h", symbol, want.symbol));
        if (last_of_byte !== want.last_of_byte)
          report_mismatch($sformatf("last_of_byte %b, predicted %b on symbol %02h",
                                    last_of_byte, want.last_of_byte, want.symbol));
        if (all_done !== want.all_done)
          report_mismatch($sformatf("all_done %b, predicted %b on symbol %02h",
                                    all_done, want.all_done, want.symbol));
      end
    end
  end

  // Hang guard: far beyond the slowest legal run
  initial begin
    #(TIMEOUT_NS);
    $display("huffman_tree_walk_decoder_unit_test: done, errors");
    $finish;
  end

  initial begin
    // Hold reset at the start, then release it for good
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_table_preload();
    test_zero_total();
    test_full_depth_tree();
    test_hand_built_tree();
    test_unit_branch_count();
    test_early_stop();
    test_random_streams();
    settle();
    if (mismatch_count == 0)
      $display("huffman_tree_walk_decoder_unit_test: done, clean");
    else
      $display("huffman_tree_walk_decoder_unit_test: done, errors");
    $finish;
  end

endmodule
